/* src/ffa_pkg.sv */
// shared types, constants and helpers of the first-fit arena allocator
`default_nettype none
package ffa_pkg;

    localparam int ARENA_BYTES = 4096;
    localparam int ADDR_W = $clog2(ARENA_BYTES);
    // walk positions may run past the arena end by up to one block size
    localparam int POS_W = 14;
    localparam int SIZE_W = 13;

    localparam logic [POS_W-1:0] ARENA_POS = POS_W'(ARENA_BYTES);
    localparam logic [POS_W-1:0] ARENA_M1 = POS_W'(ARENA_BYTES - 1);
    localparam logic [POS_W-1:0] ARENA_M2 = POS_W'(ARENA_BYTES - 2);
    localparam logic [11:0] MAX_REQ = 12'(ARENA_BYTES - 2);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE = 1'b1;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_ZERO_SIZE = 3'd1;
    localparam logic [2:0] ST_TOO_LARGE = 3'd2;
    localparam logic [2:0] ST_NO_SPACE = 3'd3;
    localparam logic [2:0] ST_NOT_ALLOC = 3'd4;

    localparam logic [7:0] USE_CLEAR_MASK = 8'd127;

    typedef struct packed {
        logic        op;
        logic [11:0] req_bytes;
        logic [11:0] payload_offset;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] granted_offset;
    } rsp_t;

    // decoded header plus position advanced by the block size
    typedef struct packed {
        logic              in_use;
        logic              size_zero;
        logic [SIZE_W-1:0] size;
        logic [POS_W-1:0]  sum;
    } hdr_info_t;

    // first header byte: in-use bit and high size bits
    function automatic logic [7:0] hdr_byte0(input logic [SIZE_W-1:0] total,
                                             input logic used);
        return {used, 2'b00, total[12:8]};
    endfunction

    // second header byte: low size bits
    function automatic logic [7:0] hdr_byte1(input logic [SIZE_W-1:0] total);
        return total[7:0];
    endfunction

endpackage
`default_nettype wire

/* src/first_fit_arena_allocator_unit.sv */
// top level: request sequencer walking block headers in the arena ram
// sequencing: a rejected alloc goes straight to S_DONE; a walk fetches each header
//   in S_F0, S_F1, S_F2 and then decides, and a header write uses S_W0 and, for two bytes, S_W1
// throughput: one request at a time, the next is taken once the previous ends
// reset: a clearing pass writes zero to all 4096 arena bytes, one a cycle,
//   and no request is taken until the pass ends
`default_nettype none
module first_fit_arena_allocator_unit
    import ffa_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_F0, S_F1, S_F2, S_W0, S_W1,
        A_FF, A_FS, A_FIT, A_HDR, A_USED, A_OK,
        F_EVAL, C_START, C_EVAL, C_IN, C_NEXT, S_DONE
    } state_t;

    state_t state_reg, state_next, ret_reg, ret_next, wret_reg, wret_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [POS_W-1:0] fa_reg, fa_next, pos_reg, pos_next, st_reg, st_next;
    logic [POS_W-1:0] en_reg, en_next, j_reg, j_next, len_reg, len_next;
    logic [POS_W-1:0] wa_reg, wa_next;
    logic [SIZE_W-1:0] n_reg, n_next;
    logic [11:0] off_reg, off_next;
    logic [7:0] b0_reg, b0_next, b1_reg, b1_next, wd0_reg, wd0_next, wd1_reg, wd1_next;
    logic wone_reg, wone_next;
    logic [2:0] status_reg, status_next;
    logic [11:0] grant_reg, grant_next;
    logic rsp_valid_reg, rsp_valid_next;
    rsp_t rsp_reg, rsp_next;

    logic [POS_W-1:0] fa1, wa1, step_base;
    logic [7:0] rdata, wdata;
    logic [ADDR_W-1:0] raddr, waddr;
    logic we;
    hdr_info_t hi;

    assign fa1 = fa_reg + POS_W'(1);
    assign wa1 = wa_reg + POS_W'(1);

    // arena store
    ffa_ram #(.WIDTH(8), .DEPTH(ARENA_BYTES)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    // shared decode and adder, base picks the walk pointer
    assign step_base = (state_reg == C_IN) ? j_reg : pos_reg;
    ffa_step_unit u_step (.base(step_base), .byte0(b0_reg), .byte1(b1_reg), .info(hi));

    // memory port steering
    always_comb
    begin
        raddr = (state_reg == S_F0) ? fa_reg[ADDR_W-1:0] : fa1[ADDR_W-1:0];
        we = 1'b0;
        waddr = wa_reg[ADDR_W-1:0];
        wdata = wd0_reg;
        case (state_reg)
            S_CLEAR:
            begin
                we = 1'b1;
                waddr = clr_reg;
                wdata = '0;
            end
            S_W0:
            begin
                we = (wa_reg < ARENA_POS);
            end
            S_W1:
            begin
                we = (wa1 < ARENA_POS);
                waddr = wa1[ADDR_W-1:0];
                wdata = wd1_reg;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        ret_next = ret_reg;
        wret_next = wret_reg;
        clr_next = clr_reg;
        fa_next = fa_reg;
        pos_next = pos_reg;
        st_next = st_reg;
        en_next = en_reg;
        j_next = j_reg;
        len_next = len_reg;
        wa_next = wa_reg;
        n_next = n_reg;
        off_next = off_reg;
        b0_next = b0_reg;
        b1_next = b1_reg;
        wd0_next = wd0_reg;
        wd1_next = wd1_reg;
        wone_next = wone_reg;
        status_next = status_reg;
        grant_next = grant_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next = rsp_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(ARENA_BYTES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    n_next = SIZE_W'(req.req_bytes);
                    off_next = req.payload_offset;
                    grant_next = '0;
                    pos_next = '0;
                    fa_next = '0;
                    if (req.op == OP_FREE)
                    begin
                        ret_next = F_EVAL;
                        state_next = S_F0;
                    end
                    else if (req.req_bytes == '0)
                    begin
                        status_next = ST_ZERO_SIZE;
                        state_next = S_DONE;
                    end
                    else if (req.req_bytes > MAX_REQ)
                    begin
                        status_next = ST_TOO_LARGE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ret_next = A_FF;
                        state_next = S_F0;
                    end
                end
            end
            // header fetch, bytes past the arena end read as zero
            S_F0:
            begin
                state_next = S_F1;
            end
            S_F1:
            begin
                b0_next = (fa_reg < ARENA_POS) ? rdata : '0;
                state_next = S_F2;
            end
            S_F2:
            begin
                b1_next = (fa1 < ARENA_POS) ? rdata : '0;
                state_next = ret_reg;
            end
            // header write, one or two bytes
            S_W0:
            begin
                state_next = wone_reg ? wret_reg : S_W1;
            end
            S_W1:
            begin
                state_next = wret_reg;
            end
            // skip in-use blocks to the next free position
            A_FF:
            begin
                if (hi.in_use)
                begin
                    if (hi.size_zero)
                    begin
                        status_next = ST_NO_SPACE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        pos_next = hi.sum;
                        fa_next = hi.sum;
                        state_next = S_F0;
                    end
                end
                else if (pos_reg < ARENA_M2)
                begin
                    st_next = pos_reg;
                    state_next = A_FS;
                end
                else
                begin
                    status_next = ST_NO_SPACE;
                    state_next = S_DONE;
                end
            end
            // run over free blocks to the next in-use header
            A_FS:
            begin
                if (!hi.in_use && !hi.size_zero)
                begin
                    pos_next = hi.sum;
                    fa_next = hi.sum;
                    ret_next = A_FS;
                    state_next = S_F0;
                end
                else
                begin
                    en_next = hi.in_use ? pos_reg : ARENA_POS;
                    state_next = A_FIT;
                end
            end
            // gap fit check
            A_FIT:
            begin
                if ((en_reg - st_reg) < (POS_W'(n_reg) + POS_W'(2)))
                begin
                    pos_next = en_reg;
                    fa_next = en_reg;
                    ret_next = A_FF;
                end
                else
                begin
                    fa_next = st_reg;
                    ret_next = A_HDR;
                end
                state_next = S_F0;
            end
            // split off the remainder, else take the whole block (one extra byte when only one would remain)
            A_HDR:
            begin
                if ((n_reg + SIZE_W'(3)) < hi.size)
                begin
                    wa_next = st_reg + POS_W'(n_reg) + POS_W'(2);
                    wd0_next = hdr_byte0(hi.size - n_reg - SIZE_W'(2), 1'b0);
                    wd1_next = hdr_byte1(hi.size - n_reg - SIZE_W'(2));
                    wone_next = 1'b0;
                    wret_next = A_USED;
                    state_next = S_W0;
                end
                else
                begin
                    if ((n_reg + SIZE_W'(3)) == hi.size)
                    begin
                        n_next = n_reg + SIZE_W'(1);
                    end
                    state_next = A_USED;
                end
            end
            A_USED:
            begin
                wa_next = st_reg;
                wd0_next = hdr_byte0(n_reg + SIZE_W'(2), 1'b1);
                wd1_next = hdr_byte1(n_reg + SIZE_W'(2));
                wone_next = 1'b0;
                wret_next = A_OK;
                state_next = S_W0;
            end
            A_OK:
            begin
                status_next = ST_OK;
                grant_next = 12'(st_reg + POS_W'(2));
                state_next = S_DONE;
            end
            // free: walk to the block whose payload matches
            F_EVAL:
            begin
                if (!(pos_reg < ARENA_M1))
                begin
                    status_next = ST_NOT_ALLOC;
                    state_next = S_DONE;
                end
                else if (POS_W'(off_reg) == pos_reg + POS_W'(2))
                begin
                    if (hi.in_use)
                    begin
                        wa_next = pos_reg;
                        wd0_next = b0_reg & USE_CLEAR_MASK;
                        wone_next = 1'b1;
                        wret_next = C_START;
                        state_next = S_W0;
                    end
                    else
                    begin
                        status_next = ST_NOT_ALLOC;
                        state_next = S_DONE;
                    end
                end
                else if ((POS_W'(off_reg) < pos_reg + POS_W'(2)) || hi.size_zero)
                begin
                    status_next = ST_NOT_ALLOC;
                    state_next = S_DONE;
                end
                else
                begin
                    pos_next = hi.sum;
                    fa_next = hi.sum;
                    state_next = S_F0;
                end
            end
            // coalesce walk from the arena start
            C_START:
            begin
                pos_next = '0;
                fa_next = '0;
                ret_next = C_EVAL;
                state_next = S_F0;
            end
            C_EVAL:
            begin
                if (!(pos_reg < ARENA_M1) || hi.size_zero)
                begin
                    status_next = ST_OK;
                    state_next = S_DONE;
                end
                else if (hi.in_use)
                begin
                    pos_next = hi.sum;
                    fa_next = hi.sum;
                    state_next = S_F0;
                end
                else
                begin
                    len_next = POS_W'(hi.size);
                    j_next = hi.sum;
                    fa_next = hi.sum;
                    ret_next = C_IN;
                    state_next = S_F0;
                end
            end
            C_IN:
            begin
                if ((j_reg < ARENA_M1) && !hi.in_use && !hi.size_zero)
                begin
                    len_next = len_reg + POS_W'(hi.size);
                    j_next = hi.sum;
                    fa_next = hi.sum;
                    state_next = S_F0;
                end
                else
                begin
                    wa_next = pos_reg;
                    wd0_next = hdr_byte0(len_reg[SIZE_W-1:0], 1'b0);
                    wd1_next = hdr_byte1(len_reg[SIZE_W-1:0]);
                    wone_next = 1'b0;
                    wret_next = C_NEXT;
                    state_next = S_W0;
                end
            end
            C_NEXT:
            begin
                pos_next = j_reg;
                fa_next = j_reg;
                ret_next = C_EVAL;
                state_next = S_F0;
            end
            // hand the result to the output register
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next.status = status_reg;
                    rsp_next.granted_offset = (status_reg == ST_OK) ? grant_reg : '0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ret_reg <= S_IDLE;
            wret_reg <= S_IDLE;
            clr_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg <= ret_next;
            wret_reg <= wret_next;
            clr_reg <= clr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        fa_reg <= fa_next;
        pos_reg <= pos_next;
        st_reg <= st_next;
        en_reg <= en_next;
        j_reg <= j_next;
        len_reg <= len_next;
        wa_reg <= wa_next;
        n_reg <= n_next;
        off_reg <= off_next;
        b0_reg <= b0_next;
        b1_reg <= b1_next;
        wd0_reg <= wd0_next;
        wd1_reg <= wd1_next;
        wone_reg <= wone_next;
        status_reg <= status_next;
        grant_reg <= grant_next;
        rsp_reg <= rsp_next;
    end

endmodule
`default_nettype wire

/* src/ffa_ram.sv */
// generic single-port-write ram with registered read
`default_nettype none
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* src/ffa_step_unit.sv */
// shared header decode and position adder used by every walk
`default_nettype none
module ffa_step_unit
    import ffa_pkg::*;
(
    input  wire logic [POS_W-1:0] base,
    input  wire logic [7:0]       byte0,
    input  wire logic [7:0]       byte1,
    output hdr_info_t             info
);

    logic [SIZE_W-1:0] size;

    // decode size and advance
    always_comb
    begin
        size = {byte0[4:0], byte1};
        info.in_use = byte0[7];
        info.size = size;
        info.size_zero = (size == '0);
        info.sum = base + POS_W'(size);
    end

endmodule
`default_nettype wire

/* src/ffa_checker.sv */
// port-level checker for the allocator and its bind
`default_nettype none
module ffa_checker
    import ffa_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_stall,
    input wire logic rsp_valid,
    input wire logic rsp_stall,
    input wire rsp_t rsp
);

    // status code in range
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.status <= ST_NOT_ALLOC))
        else $error("status out of range");

    // failed request carries no offset
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status != ST_OK) |-> (rsp.granted_offset == '0))
        else $error("offset on failed request");

    // granted payload sits past a header
    a_grant_min: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.granted_offset != '0) |-> (rsp.granted_offset >= 12'd2))
        else $error("granted offset inside first header");

    // stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled result changed");

    // an accepted request is followed by a stalled input
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request taken while busy");

endmodule

bind first_fit_arena_allocator_unit ffa_checker u_ffa_checker (
    .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req_stall(req_stall),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
);
`default_nettype wire
